// ===== hdl/scc_pkg.sv =====
package scc_pkg;

  // Default limits for the top level parameters.
  localparam int MAX_FANINS_DEF = 64;
  localparam int MAX_CUBES_DEF  = 4096;

  localparam int COL_W = 7;
  localparam logic [COL_W-1:0] SMALL_MAX = 7'd127;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_DASH    = 8'h2D;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_ONE     = 8'h31;

  typedef enum logic [1:0] {
    STAGE_INPUT   = 2'd0,
    STAGE_PHASE   = 2'd1,
    STAGE_NEWLINE = 2'd2
  } stage_e;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_WIDTH   = 3'd1,
    ERR_PHASE   = 3'd2,
    ERR_NEWLINE = 3'd3,
    ERR_MIXED   = 3'd4,
    ERR_TRUNC   = 3'd5
  } err_e;

  typedef logic [6:0]  fanin_t;
  typedef logic [12:0] cube_total_t;
  typedef logic [18:0] literal_total_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       final_symbol;
  } sym_t;

  typedef struct packed {
    logic [2:0]     error_code;
    cube_total_t    cube_total;
    literal_total_t literal_total;
    logic           output_phase;
    logic           and_kind;
    logic           or_kind;
  } verdict_t;

endpackage

// ===== hdl/scc_in_stage.sv =====
module scc_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  scc_pkg::sym_t in_data_i,
  output logic          sym_valid_o,
  input  logic          sym_ready_i,
  output scc_pkg::sym_t sym_data_o
);

  logic          valid_q, valid_d;
  scc_pkg::sym_t data_q;
  logic          load;

  // The register takes a new character whenever it is empty or its
  // current one moves on in the same cycle.
  assign in_ready_o = !valid_q || sym_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (sym_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= in_data_i;
    end
  end

  assign sym_valid_o = valid_q;
  assign sym_data_o  = data_q;

endmodule

// ===== hdl/scc_parser.sv =====
module scc_parser #(
  parameter int MAX_FANINS = scc_pkg::MAX_FANINS_DEF,
  parameter int MAX_CUBES  = scc_pkg::MAX_CUBES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  scc_pkg::fanin_t   cfg_data_i,
  input  logic              step_i,
  input  scc_pkg::sym_t     sym_i,
  output scc_pkg::verdict_t verdict_o
);

  localparam int LitLimit = MAX_FANINS * MAX_CUBES;
  localparam int CubeW    = $clog2(MAX_CUBES + 1);
  localparam int LitW     = $clog2(LitLimit + 1);
  localparam int CmpW     = (CubeW > scc_pkg::COL_W) ? CubeW : scc_pkg::COL_W;

  scc_pkg::fanin_t              fanin_q;
  logic [scc_pkg::COL_W-1:0]    column_q, column_d;
  scc_pkg::stage_e              stage_q, stage_d;
  logic                         zero_q, zero_d;
  logic                         one_q, one_d;
  scc_pkg::err_e                err_q, err_d;
  logic [CubeW-1:0]             cubes_q, cubes_d;
  logic [LitW-1:0]              lits_q, lits_d;
  logic [scc_pkg::COL_W-1:0]    cube_lits_q, cube_lits_d;
  logic                         dash_q, dash_d;
  logic                         single_q, single_d;
  logic                         ok;
  logic [7:0]                   c;

  assign c = sym_i.symbol;

  always_comb begin
    column_d    = column_q;
    stage_d     = stage_q;
    zero_d      = zero_q;
    one_d       = one_q;
    err_d       = err_q;
    cubes_d     = cubes_q;
    lits_d      = lits_q;
    cube_lits_d = cube_lits_q;
    dash_d      = dash_q;
    single_d    = single_q;
    ok          = 1'b0;
    verdict_o   = '0;

    if (step_i) begin
      case (stage_q)
        scc_pkg::STAGE_INPUT: begin
          if (c == scc_pkg::CHAR_SPACE) begin
            if (column_q != fanin_q && err_d == scc_pkg::ERR_NONE) begin
              err_d = scc_pkg::ERR_WIDTH;
            end
            stage_d = scc_pkg::STAGE_PHASE;
          end else begin
            if (column_q < scc_pkg::SMALL_MAX) begin
              column_d = column_q + 1'b1;
            end
            if ((c == scc_pkg::CHAR_ZERO || c == scc_pkg::CHAR_ONE) &&
                lits_q < LitW'(LitLimit)) begin
              lits_d = lits_q + 1'b1;
            end
            if (c == scc_pkg::CHAR_DASH) begin
              dash_d = 1'b1;
            end else if (cube_lits_q < scc_pkg::SMALL_MAX) begin
              cube_lits_d = cube_lits_q + 1'b1;
            end
          end
        end
        scc_pkg::STAGE_PHASE: begin
          if (c == scc_pkg::CHAR_ZERO) begin
            zero_d = 1'b1;
          end else if (c == scc_pkg::CHAR_ONE) begin
            one_d = 1'b1;
          end else if (err_d == scc_pkg::ERR_NONE) begin
            err_d = scc_pkg::ERR_PHASE;
          end
          stage_d = scc_pkg::STAGE_NEWLINE;
        end
        default: begin
          if (c == scc_pkg::CHAR_NEWLINE) begin
            if (cubes_q < CubeW'(MAX_CUBES)) begin
              cubes_d = cubes_q + 1'b1;
            end
            if (cube_lits_q != scc_pkg::COL_W'(1)) begin
              single_d = 1'b0;
            end
          end else if (err_d == scc_pkg::ERR_NONE) begin
            err_d = scc_pkg::ERR_NEWLINE;
          end
          column_d    = '0;
          cube_lits_d = '0;
          stage_d     = scc_pkg::STAGE_INPUT;
        end
      endcase

      if (sym_i.final_symbol) begin
        // A cover must end right after a newline.
        if ((stage_d != scc_pkg::STAGE_INPUT || column_d != '0) &&
            err_d == scc_pkg::ERR_NONE) begin
          err_d = scc_pkg::ERR_TRUNC;
        end
        if (zero_d && one_d && err_d == scc_pkg::ERR_NONE) begin
          err_d = scc_pkg::ERR_MIXED;
        end
        ok = (err_d == scc_pkg::ERR_NONE);

        verdict_o.error_code    = err_d;
        verdict_o.cube_total    = scc_pkg::cube_total_t'(cubes_d);
        verdict_o.literal_total = scc_pkg::literal_total_t'(lits_d);
        verdict_o.output_phase  = ok && one_d;
        verdict_o.and_kind      = ok && cubes_d == CubeW'(1) && !dash_d && one_d;
        verdict_o.or_kind       = ok && CmpW'(cubes_d) == CmpW'(fanin_q) && single_d;

        // The next cover starts from a clean parse state.
        column_d    = '0;
        stage_d     = scc_pkg::STAGE_INPUT;
        zero_d      = 1'b0;
        one_d       = 1'b0;
        err_d       = scc_pkg::ERR_NONE;
        cubes_d     = '0;
        lits_d      = '0;
        cube_lits_d = '0;
        dash_d      = 1'b0;
        single_d    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fanin_q     <= '0;
      column_q    <= '0;
      stage_q     <= scc_pkg::STAGE_INPUT;
      zero_q      <= 1'b0;
      one_q       <= 1'b0;
      err_q       <= scc_pkg::ERR_NONE;
      cubes_q     <= '0;
      lits_q      <= '0;
      cube_lits_q <= '0;
      dash_q      <= 1'b0;
      single_q    <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        fanin_q <= cfg_data_i;
      end
      column_q    <= column_d;
      stage_q     <= stage_d;
      zero_q      <= zero_d;
      one_q       <= one_d;
      err_q       <= err_d;
      cubes_q     <= cubes_d;
      lits_q      <= lits_d;
      cube_lits_q <= cube_lits_d;
      dash_q      <= dash_d;
      single_q    <= single_d;
    end
  end

endmodule

// ===== hdl/scc_out_stage.sv =====
module scc_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  scc_pkg::verdict_t verdict_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output scc_pkg::verdict_t out_data_o
);

  logic              valid_q, valid_d;
  scc_pkg::verdict_t data_q;

  // Free when empty or when the held verdict is transferred this cycle.
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= verdict_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== hdl/sop_cover_checker.sv =====
// A verdict is loaded into the result register when its final character leaves the input register.
// Throughput: one character per cycle; the input register stalls only when a final
// character meets a verdict that has not yet been taken at the output.
// Reset (rst_ni low, asynchronous): parse state cleared, fanin_q cleared to zero,
// both registers empty. No clearing pass; the block takes input right after reset.
module sop_cover_checker #(
  parameter int MAX_FANINS = scc_pkg::MAX_FANINS_DEF,
  parameter int MAX_CUBES  = scc_pkg::MAX_CUBES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  scc_pkg::fanin_t   cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  scc_pkg::sym_t     in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output scc_pkg::verdict_t out_data_o
);

  logic              sym_valid;
  logic              sym_ready;
  scc_pkg::sym_t     sym_data;
  logic              step;
  logic              out_free;
  scc_pkg::verdict_t verdict;

  scc_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .sym_valid_o (sym_valid),
    .sym_ready_i (sym_ready),
    .sym_data_o  (sym_data)
  );

  // Only a final character needs room in the result register.
  assign sym_ready = !sym_data.final_symbol || out_free;
  assign step      = sym_valid && sym_ready;

  scc_parser #(
    .MAX_FANINS (MAX_FANINS),
    .MAX_CUBES  (MAX_CUBES)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (step),
    .sym_i      (sym_data),
    .verdict_o  (verdict)
  );

  scc_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && sym_data.final_symbol),
    .verdict_i   (verdict),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> sym_valid && sym_data.final_symbol && out_valid_o && !out_ready_i)
    else $error("input stalled without a blocked final character");

  a_error_clears_kinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.error_code != scc_pkg::ERR_NONE |->
      !out_data_o.output_phase && !out_data_o.and_kind && !out_data_o.or_kind)
    else $error("verdict with an error reports a cover kind");

  a_and_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.and_kind |->
      out_data_o.output_phase && out_data_o.cube_total == scc_pkg::cube_total_t'(1))
    else $error("AND-type verdict without a single ones-phase cube");

  a_final_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && sym_data.final_symbol |=> out_valid_o)
    else $error("final character transfer gave no verdict");

endmodule
